### hdl/fir_pkg.sv
// shared types and constants for the programmable fir filter
// no dependencies; compile first

package fir_pkg;

	localparam int COEF_BITS    = 16;
	localparam int NUM_COEFS    = 7;
	localparam int CFG_IDX_BITS = 3;
	localparam int TAP_CNT_BITS = 3;

	// adder tree: eight leaves, three registered levels
	localparam int TREE_LEAVES = 8;
	localparam int GROW_BITS   = 3;

	// q4.12 * q2.14 gives q.26, back to q.12
	localparam int FRAC_DROP  = 14;
	localparam int ROUND_HALF = 1 << (FRAC_DROP - 1);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TAP_COUNT = 3'd0,
		REG_COEF_0    = 3'd1,
		REG_COEF_1    = 3'd2,
		REG_COEF_2    = 3'd3,
		REG_COEF_3    = 3'd4,
		REG_COEF_4    = 3'd5,
		REG_COEF_5    = 3'd6,
		REG_COEF_6    = 3'd7
	} cfg_reg_t;

	localparam logic [TAP_CNT_BITS-1:0] TAP_COUNT_RESET = 3'd3;

	localparam logic signed [COEF_BITS-1:0] COEF_RESET [NUM_COEFS] = '{
		16'sd4096, 16'sd8192, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0
	};

	// per-cycle control handed to every cell
	typedef struct packed {
		logic adv;    // pipeline moves
		logic shift;  // a sample request is taken, history shifts
		logic clr;    // first sample of a block
	} cell_ctl_t;

endpackage

### hdl/fir_if.sv
// valid/ready channel interfaces for the fir filter: sample in, sample out, config
// depends on fir_pkg

interface fir_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          block_start;

	modport source (output valid, output sample_in, output block_start, input ready);
	modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

interface fir_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface fir_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [fir_pkg::CFG_IDX_BITS-1:0]     index;
	logic [fir_pkg::COEF_BITS-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/programmable_fir_filter.sv
// programmable fir filter, up to MAX_TAPS taps, as a row of tap cells
// a taken sample passes the product register, three adder levels and the round register to the result
// throughput: one sample per cycle; the whole pipeline holds while the result is not taken
// reset: history cleared, tap count 3, coefficients 4096, 8192, 4096, then zeros
// depends on fir_pkg, fir_if, fir_cell, fir_sum, fir_out

module programmable_fir_filter #(
	parameter int MAX_TAPS    = 7,
	parameter int SAMPLE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	fir_in_if.sink    din,
	fir_out_if.source dout,
	fir_cfg_if.sink   cfg
);
	import fir_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W  = PROD_W + GROW_BITS;

	logic [TAP_CNT_BITS-1:0]      tap_cnt_q;
	logic signed [COEF_BITS-1:0]  coef_q [NUM_COEFS];
	logic [CFG_IDX_BITS-1:0]      coef_sel;

	logic                          adv;
	logic                          take;
	cell_ctl_t                     ctl;
	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [SAMPLE_BITS-1:0] chain [MAX_TAPS];
	logic signed [PROD_W-1:0]      prod_s1 [MAX_TAPS];
	logic signed [ACC_W-1:0]       sum_s4;

	// configuration
	assign cfg.ready = 1'b1;
	assign coef_sel  = cfg.index - REG_COEF_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_cnt_q <= TAP_COUNT_RESET;
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= COEF_RESET[i];
			end
		end else if (cfg.valid) begin
			if (cfg_reg_t'(cfg.index) == REG_TAP_COUNT) begin
				tap_cnt_q <= cfg.data[TAP_CNT_BITS-1:0];
			end else begin
				coef_q[coef_sel] <= cfg.data;
			end
		end
	end

	// pipeline control
	assign adv       = !vld_s5 || dout.ready;
	assign take      = din.valid && adv;
	assign din.ready = adv;

	assign ctl.adv   = adv;
	assign ctl.shift = take;
	assign ctl.clr   = din.block_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= din.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// tap cells, each but the last hands its history sample to the next
	assign chain[0] = din.sample_in;

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		logic tap_on;

		// tap k is active when k is below the tap count, clamping is implied
		assign tap_on = tap_cnt_q > TAP_CNT_BITS'(k);

		if (k < MAX_TAPS - 1) begin : g_mid
			fir_cell #(
				.SAMPLE_BITS (SAMPLE_BITS),
				.FIRST       (k == 0),
				.KEEP        (1'b1)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.tap_on  (tap_on),
				.coef    (coef_q[k]),
				.left    (chain[k]),
				.hist    (chain[k+1]),
				.prod_s1 (prod_s1[k])
			);
		end else begin : g_last
			fir_cell #(
				.SAMPLE_BITS (SAMPLE_BITS),
				.FIRST       (k == 0),
				.KEEP        (1'b0)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.tap_on  (tap_on),
				.coef    (coef_q[k]),
				.left    (chain[k]),
				.hist    (),
				.prod_s1 (prod_s1[k])
			);
		end
	end

	fir_sum #(
		.MAX_TAPS (MAX_TAPS),
		.PROD_W   (PROD_W),
		.ACC_W    (ACC_W)
	) u_sum (
		.clk    (clk),
		.adv    (adv),
		.prod   (prod_s1),
		.sum_s4 (sum_s4)
	);

	fir_out #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.ACC_W       (ACC_W)
	) u_out (
		.clk        (clk),
		.adv        (adv),
		.sum        (sum_s4),
		.sample_out (dout.sample_out),
		.clipped    (dout.clipped)
	);

	assign dout.valid = vld_s5;

endmodule

### hdl/fir_cell.sv
// tap cell: registers its product; with KEEP, holds a history sample for the next cell
// depends on fir_pkg

module fir_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter bit FIRST       = 1'b0,
	parameter bit KEEP        = 1'b1
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  fir_pkg::cell_ctl_t                              ctl,
	input  logic                                            tap_on,
	input  logic signed [fir_pkg::COEF_BITS-1:0]            coef,
	input  logic signed [SAMPLE_BITS-1:0]                   left,
	output logic signed [SAMPLE_BITS-1:0]                   hist,
	output logic signed [SAMPLE_BITS+fir_pkg::COEF_BITS-1:0] prod_s1
);
	import fir_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;

	logic signed [SAMPLE_BITS-1:0] tap_sample;
	logic signed [PROD_W-1:0]      prod;

	// the current sample is never cleared, only the past ones
	assign tap_sample = (!FIRST && ctl.clr) ? '0 : left;

	// kept apart from the zero fill so the multiply stays signed
	always_comb begin
		prod = '0;
		if (tap_on) begin
			prod = tap_sample * coef;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			prod_s1 <= prod;
		end
	end

	if (KEEP) begin : g_hist
		logic signed [SAMPLE_BITS-1:0] hist_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hist_q <= '0;
			end else if (ctl.shift) begin
				hist_q <= tap_sample;
			end
		end

		assign hist = hist_q;
	end else begin : g_no_hist
		assign hist = '0;
	end

endmodule

### hdl/fir_sum.sv
// registered adder tree over the tap products, three levels
// depends on fir_pkg

module fir_sum #(
	parameter int MAX_TAPS = 7,
	parameter int PROD_W   = 32,
	parameter int ACC_W    = 35
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [PROD_W-1:0] prod [MAX_TAPS],
	output logic signed [ACC_W-1:0]  sum_s4
);
	import fir_pkg::*;

	logic signed [ACC_W-1:0] leaf [TREE_LEAVES];
	logic signed [ACC_W-1:0] lvl_s2 [TREE_LEAVES/2];
	logic signed [ACC_W-1:0] lvl_s3 [TREE_LEAVES/4];

	for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
		if (i < MAX_TAPS) begin : g_tap
			assign leaf[i] = ACC_W'(prod[i]);
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < TREE_LEAVES/2; i++) begin
				lvl_s2[i] <= leaf[2*i] + leaf[2*i+1];
			end
			for (int i = 0; i < TREE_LEAVES/4; i++) begin
				lvl_s3[i] <= lvl_s2[2*i] + lvl_s2[2*i+1];
			end
			sum_s4 <= lvl_s3[0] + lvl_s3[1];
		end
	end

endmodule

### hdl/fir_out.sv
// rounds the q.26 sum to q4.12 (half up) and saturates, with a clip flag
// depends on fir_pkg

module fir_out #(
	parameter int SAMPLE_BITS = 16,
	parameter int ACC_W       = 35
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic signed [ACC_W-1:0]       sum,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          clipped
);
	import fir_pkg::*;

	localparam int T_W = ACC_W + 1;
	localparam int Y_W = T_W - FRAC_DROP;

	logic signed [T_W-1:0]         rnd;
	logic        [Y_W-1:0]         y;
	logic        [Y_W-SAMPLE_BITS:0] top_bits;
	logic                          sat;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic signed [SAMPLE_BITS-1:0] sample_s5;
	logic                          clip_s5;

	assign rnd      = T_W'(sum) + T_W'(ROUND_HALF);
	assign y        = rnd[T_W-1:FRAC_DROP];
	assign top_bits = y[Y_W-1:SAMPLE_BITS-1];
	assign sat      = !((&top_bits) || (~|top_bits));

	always_comb begin
		if (!sat) begin
			y_sat = y[SAMPLE_BITS-1:0];
		end else if (y[Y_W-1]) begin
			y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s5 <= y_sat;
			clip_s5   <= sat;
		end
	end

	assign sample_out = sample_s5;
	assign clipped    = clip_s5;

endmodule
